FILE: src/kvh_pkg.sv
// Shared constants, types and the key ordering function of the key/value
// binary heap. Depends on nothing; used by the heap top level and its checker.
package kvh_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CH_W     = IDX_W + 2;
  localparam int DATA_W   = 32;
  localparam int STAT_W   = 2;
  localparam int OCC_W    = 9;

  // operation codes
  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  // order mode codes
  localparam logic MODE_MAX = 1'b0;
  localparam logic MODE_MIN = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } entry_t;

  // true when key a must sit strictly above key b in the current order
  function automatic logic outranks(logic mode, logic signed [DATA_W-1:0] a,
                                    logic signed [DATA_W-1:0] b);
    outranks = (mode == MODE_MIN) ? (a < b) : (a > b);
  endfunction

endpackage

FILE: src/key_value_binary_heap.sv
// Binary-heap priority queue of signed key/value pairs held in a dual-read
// synchronous memory. Depends on kvh_pkg for widths, codes and ordering.
//
// An operation is taken when start is high and busy low; its one result shows
// on the out_ ports for a single cycle with out_valid, and cannot be held off.
// An insert on a full heap or an extract on an empty heap reports in the next
// cycle and busy stays low. An insert into an empty heap also reports in the
// next cycle. Otherwise busy stays high while the sift walks the heap level
// by level, reading, comparing and writing the memory at each step. The
// memory needs no clearing after reset. The user must write order_mode
// through cfg_we/cfg_wdata only while the block is idle; the block itself
// does not enforce this.
module key_value_binary_heap (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic                                 cfg_wdata,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_func,
  input  logic signed [kvh_pkg::DATA_W-1:0]    in_key,
  input  logic signed [kvh_pkg::DATA_W-1:0]    in_value,
  output logic                                 out_valid,
  output logic        [kvh_pkg::STAT_W-1:0]    out_status,
  output logic signed [kvh_pkg::DATA_W-1:0]    out_key,
  output logic signed [kvh_pkg::DATA_W-1:0]    out_value,
  output logic        [kvh_pkg::OCC_W-1:0]     out_occupancy
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_UP      = 3'd1;
  localparam logic [2:0] ST_UP_ROOT = 3'd2;
  localparam logic [2:0] ST_DN_LOAD = 3'd3;
  localparam logic [2:0] ST_DN      = 3'd4;

  logic [2:0]                     state_r, state_nxt;
  logic [kvh_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic                           mode_r;
  kvh_pkg::entry_t                item_r, item_nxt;
  logic [kvh_pkg::IDX_W-1:0]      pos_r, pos_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [kvh_pkg::STAT_W-1:0]     out_status_r, out_status_nxt;
  logic signed [kvh_pkg::DATA_W-1:0] out_key_r, out_key_nxt;
  logic signed [kvh_pkg::DATA_W-1:0] out_value_r, out_value_nxt;
  logic [kvh_pkg::OCC_W-1:0]      out_occ_r, out_occ_nxt;

  // heap storage, one write port and two registered read ports
  kvh_pkg::entry_t                mem [kvh_pkg::CAPACITY];
  kvh_pkg::entry_t                rd_a_r, rd_b_r, wr_data;
  logic [kvh_pkg::IDX_W-1:0]      rd_addr_a, rd_addr_b, wr_addr;
  logic                           wr_en;

  // sift helpers
  logic [kvh_pkg::IDX_W-1:0]      up_parent, up_grand, cnt_parent;
  logic [kvh_pkg::CH_W-1:0]       left_idx, right_idx, cnt_ext;
  logic [kvh_pkg::CH_W-1:0]       nl_idx, nr_idx;
  logic                           left_ok, right_ok, take_left, take_right;
  logic [kvh_pkg::IDX_W-1:0]      child_idx;
  kvh_pkg::entry_t                child_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  assign cnt_parent = kvh_pkg::IDX_W'((count_r - 1'b1) >> 1);
  assign up_parent  = (pos_r - 1'b1) >> 1;
  assign up_grand   = (up_parent - 1'b1) >> 1;
  assign cnt_ext    = kvh_pkg::CH_W'(count_r);
  assign left_idx   = {1'b0, pos_r, 1'b1};
  assign right_idx  = kvh_pkg::CH_W'({1'b0, pos_r, 1'b1}) + 1'b1;
  assign left_ok    = left_idx < cnt_ext;
  assign right_ok   = right_idx < cnt_ext;

  // pick the strictly best of moving item, left and right child
  always_comb begin
    take_left  = left_ok && kvh_pkg::outranks(mode_r, rd_a_r.key, item_r.key);
    take_right = right_ok && (take_left ?
                 kvh_pkg::outranks(mode_r, rd_b_r.key, rd_a_r.key) :
                 kvh_pkg::outranks(mode_r, rd_b_r.key, item_r.key));
    child_idx  = take_right ? right_idx[kvh_pkg::IDX_W-1:0]
                            : left_idx[kvh_pkg::IDX_W-1:0];
    child_data = take_right ? rd_b_r : rd_a_r;
    nl_idx     = {1'b0, child_idx, 1'b1};
    nr_idx     = nl_idx + 1'b1;
  end

  // operation sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    item_nxt       = item_r;
    pos_nxt        = pos_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_value_nxt  = out_value_r;
    out_occ_nxt    = out_occ_r;
    rd_addr_a      = '0;
    rd_addr_b      = '0;
    wr_en          = 1'b0;
    wr_addr        = pos_r;
    wr_data        = item_r;

    unique case (state_r)
      ST_IDLE: begin
        rd_addr_a = (in_func == kvh_pkg::FUNC_INSERT) ? cnt_parent : '0;
        rd_addr_b = kvh_pkg::IDX_W'(count_r - 1'b1);
        if (start) begin
          out_key_nxt   = '0;
          out_value_nxt = '0;
          if (in_func == kvh_pkg::FUNC_INSERT) begin
            if (count_r == kvh_pkg::CNT_W'(kvh_pkg::CAPACITY)) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = kvh_pkg::STAT_OVERFLOW;
              out_occ_nxt    = kvh_pkg::OCC_W'(count_r);
            end else if (count_r == '0) begin
              wr_en          = 1'b1;
              wr_addr        = '0;
              wr_data        = '{key: in_key, value: in_value};
              count_nxt      = kvh_pkg::CNT_W'(1);
              out_valid_nxt  = 1'b1;
              out_status_nxt = kvh_pkg::STAT_OK;
              out_occ_nxt    = kvh_pkg::OCC_W'(1);
            end else begin
              item_nxt  = '{key: in_key, value: in_value};
              pos_nxt   = kvh_pkg::IDX_W'(count_r);
              count_nxt = count_r + 1'b1;
              state_nxt = ST_UP;
            end
          end else begin
            if (count_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = kvh_pkg::STAT_EMPTY;
              out_occ_nxt    = '0;
            end else begin
              count_nxt = count_r - 1'b1;
              state_nxt = ST_DN_LOAD;
            end
          end
        end
      end

      // rd_a_r holds the parent of the hole
      ST_UP: begin
        if (kvh_pkg::outranks(mode_r, item_r.key, rd_a_r.key)) begin
          wr_en     = 1'b1;
          wr_data   = rd_a_r;
          pos_nxt   = up_parent;
          rd_addr_a = up_grand;
          if (up_parent == '0) begin
            state_nxt = ST_UP_ROOT;
          end
        end else begin
          wr_en          = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = kvh_pkg::STAT_OK;
          out_occ_nxt    = kvh_pkg::OCC_W'(count_r);
          state_nxt      = ST_IDLE;
        end
      end

      ST_UP_ROOT: begin
        wr_en          = 1'b1;
        wr_addr        = '0;
        out_valid_nxt  = 1'b1;
        out_status_nxt = kvh_pkg::STAT_OK;
        out_occ_nxt    = kvh_pkg::OCC_W'(count_r);
        state_nxt      = ST_IDLE;
      end

      // rd_a_r holds the root, rd_b_r the last pair
      ST_DN_LOAD: begin
        out_key_nxt    = rd_a_r.key;
        out_value_nxt  = rd_a_r.value;
        out_status_nxt = kvh_pkg::STAT_OK;
        out_occ_nxt    = kvh_pkg::OCC_W'(count_r);
        item_nxt       = rd_b_r;
        pos_nxt        = '0;
        rd_addr_a      = kvh_pkg::IDX_W'(1);
        rd_addr_b      = kvh_pkg::IDX_W'(2);
        if (count_r == '0) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_DN;
        end
      end

      // rd_a_r and rd_b_r hold the children of the hole
      ST_DN: begin
        wr_en = 1'b1;
        if (take_left || take_right) begin
          wr_data   = child_data;
          pos_nxt   = child_idx;
          rd_addr_a = nl_idx[kvh_pkg::IDX_W-1:0];
          rd_addr_b = nr_idx[kvh_pkg::IDX_W-1:0];
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      mode_r      <= kvh_pkg::MODE_MAX;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    pos_r        <= pos_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_value_r  <= out_value_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_key       = out_key_r;
  assign out_value     = out_value_r;
  assign out_occupancy = out_occ_r;

endmodule

FILE: src/kvh_checker.sv
// Port-level checks for the key/value binary heap, bound to its top level.
// Depends on kvh_pkg for status codes and capacity.
module kvh_port_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic [kvh_pkg::STAT_W-1:0]        out_status,
  input logic signed [kvh_pkg::DATA_W-1:0] out_key,
  input logic signed [kvh_pkg::DATA_W-1:0] out_value,
  input logic [kvh_pkg::OCC_W-1:0]         out_occupancy
);

  // an accepted transfer is followed by work or a result
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted transfer produced neither busy nor a result");

  // overflow only when full
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == kvh_pkg::STAT_OVERFLOW) |->
      (out_occupancy == kvh_pkg::OCC_W'(kvh_pkg::CAPACITY)))
    else $error("overflow reported with heap not full");

  // empty only with nothing stored
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == kvh_pkg::STAT_EMPTY) |-> (out_occupancy == '0))
    else $error("empty reported with pairs stored");

  // error results carry a zero pair
  a_error_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != kvh_pkg::STAT_OK) |->
      (out_key == '0 && out_value == '0))
    else $error("error result carries a non-zero pair");

endmodule

bind key_value_binary_heap kvh_port_checker u_kvh_port_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_status    (out_status),
  .out_key       (out_key),
  .out_value     (out_value),
  .out_occupancy (out_occupancy)
);

FILE: tb/sv/kvh_checker.sv
// Checker for the key/value binary heap: watches the operation, result and
// configuration ports, predicts each result and compares it field by field.
// Depends on kvh_pkg for widths, operation, mode and status codes.
module kvh_checker
  import kvh_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_wdata,
  input  logic                      start,
  input  logic                      busy,
  input  logic                      in_func,
  input  logic signed [DATA_W-1:0]  in_key,
  input  logic signed [DATA_W-1:0]  in_value,
  input  logic                      out_valid,
  input  logic        [STAT_W-1:0]  out_status,
  input  logic signed [DATA_W-1:0]  out_key,
  input  logic signed [DATA_W-1:0]  out_value,
  input  logic        [OCC_W-1:0]   out_occupancy,
  output int                        errors,
  output int                        pending,
  output int                        heap_fill
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        [STAT_W-1:0] status;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
    logic        [OCC_W-1:0]  occ;
  } heap_result_t;

  // shadow heap and order bit
  logic signed [DATA_W-1:0] slot_key [CAPACITY];
  logic signed [DATA_W-1:0] slot_val [CAPACITY];
  int                       fill;
  logic                     mode;

  // results still owed by the block, oldest first
  heap_result_t owed_results [$];

  // strict priority test under the current order
  function automatic bit ranks_above(logic signed [DATA_W-1:0] a,
                                     logic signed [DATA_W-1:0] b);
    if (mode == MODE_MIN)
      return a < b;
    return a > b;
  endfunction

  function automatic void swap_slots(int x, int y);
    logic signed [DATA_W-1:0] tk;
    logic signed [DATA_W-1:0] tv;
    tk = slot_key[x];
    tv = slot_val[x];
    slot_key[x] = slot_key[y];
    slot_val[x] = slot_val[y];
    slot_key[y] = tk;
    slot_val[y] = tv;
  endfunction

  // apply one operation to the shadow heap and return its result
  function automatic heap_result_t apply_heap_op(logic f, logic signed [DATA_W-1:0] k,
                                                 logic signed [DATA_W-1:0] v);
    heap_result_t r;
    int i;
    int parent;
    int best;
    int left_i;
    int right_i;
    r.status = STAT_OK;
    r.key    = '0;
    r.value  = '0;
    if (f == FUNC_INSERT) begin
      if (fill >= CAPACITY) begin
        r.status = STAT_OVERFLOW;
      end else begin
        i = fill;
        slot_key[i] = k;
        slot_val[i] = v;
        fill++;
        // sift up while strictly better than the parent
        while (i > 0) begin
          parent = (i - 1) / 2;
          if (!ranks_above(slot_key[i], slot_key[parent]))
            break;
          swap_slots(i, parent);
          i = parent;
        end
      end
    end else if (fill == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      r.key   = slot_key[0];
      r.value = slot_val[0];
      fill--;
      slot_key[0] = slot_key[fill];
      slot_val[0] = slot_val[fill];
      // sift down, left child wins ties
      i = 0;
      forever begin
        best    = i;
        left_i  = 2 * i + 1;
        right_i = 2 * i + 2;
        if (left_i < fill && ranks_above(slot_key[left_i], slot_key[best]))
          best = left_i;
        if (right_i < fill && ranks_above(slot_key[right_i], slot_key[best]))
          best = right_i;
        if (best == i)
          break;
        swap_slots(i, best);
        i = best;
      end
    end
    r.occ = fill[OCC_W-1:0];
    return r;
  endfunction

  // result check first, then config and operation transfers of this edge
  always @(posedge clk) begin
    heap_result_t want;
    if (!rst_n) begin
      fill = 0;
      mode = MODE_MAX;
      owed_results.delete();
    end else begin
      if (out_valid) begin
        if (owed_results.size() == 0) begin
          errors++;
          $error("result transfer with no operation outstanding");
        end else begin
          want = owed_results.pop_front();
          if (out_status !== want.status) begin
            errors++;
            $error("status: expected %0d, actual %0d", want.status, out_status);
          end
          if (out_key !== want.key) begin
            errors++;
            $error("out_key: expected %0d, actual %0d", want.key, out_key);
          end
          if (out_value !== want.value) begin
            errors++;
            $error("out_value: expected %0d, actual %0d", want.value, out_value);
          end
          if (out_occupancy !== want.occ) begin
            errors++;
            $error("occupancy: expected %0d, actual %0d", want.occ, out_occupancy);
          end
        end
      end
      if (cfg_we)
        mode = cfg_wdata;
      if (start && !busy)
        owed_results.push_back(apply_heap_op(in_func, in_key, in_value));
    end
    pending   = owed_results.size();
    heap_fill = fill;
  end

endmodule

FILE: tb/sv/tb.sv
// Top of the key/value binary heap testbench: clock, reset, operation and
// order-mode stimulus and the verdict. Depends on kvh_pkg, the heap top level
// and kvh_checker, which does all prediction and comparison.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kvh_pkg::*;

  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 250000;
  localparam logic signed [DATA_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] KEY_MIN = 32'sh8000_0000;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     cfg_we    = 1'b0;
  logic                     cfg_wdata = 1'b0;
  logic                     start     = 1'b0;
  logic                     in_func   = FUNC_INSERT;
  logic signed [DATA_W-1:0] in_key    = '0;
  logic signed [DATA_W-1:0] in_value  = '0;
  logic                     busy;
  logic                     out_valid;
  logic        [STAT_W-1:0] out_status;
  logic signed [DATA_W-1:0] out_key;
  logic signed [DATA_W-1:0] out_value;
  logic        [OCC_W-1:0]  out_occupancy;
  int                       errors;
  int                       pending;
  int                       heap_fill;
  int                       cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  key_value_binary_heap uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_key        (in_key),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_key       (out_key),
    .out_value     (out_value),
    .out_occupancy (out_occupancy)
  );

  kvh_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_key        (in_key),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_key       (out_key),
    .out_value     (out_value),
    .out_occupancy (out_occupancy),
    .errors        (errors),
    .pending       (pending),
    .heap_fill     (heap_fill)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // drive one operation from a falling edge, hold it until the transfer
  task automatic issue(input logic f, input logic signed [DATA_W-1:0] k,
                       input logic signed [DATA_W-1:0] v);
    in_func  <= f;
    in_key   <= k;
    in_value <= v;
    start    <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic idle_gap(input int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // hold off until every result is in and the block has gone quiet
  task automatic settle();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic set_order(input logic m);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // random keys: full range, a narrow band for ties, or an extreme
  function automatic logic signed [DATA_W-1:0] pick_key();
    case ($urandom_range(2))
      0: return $urandom;
      1: return int'($urandom_range(6)) - 3;
      default: begin
        case ($urandom_range(4))
          0: return KEY_MAX;
          1: return KEY_MIN;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
    endcase
  endfunction

  // biased random operations; with a goal occupancy, run on until it has been
  // seen on ten operations
  task automatic random_run(input int insert_pct, input int idle_pct,
                            input int min_items, input int goal_fill);
    int   done;
    int   hits;
    logic f;
    done = 0;
    hits = (goal_fill < 0) ? 10 : 0;
    while (done < min_items || hits < 10) begin
      if (heap_fill == goal_fill)
        hits++;
      f = ($urandom_range(99) < insert_pct) ? FUNC_INSERT : FUNC_EXTRACT;
      issue(f, pick_key(), $urandom);
      idle_gap(idle_pct);
      done++;
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty extract, extremes, ties, order change on a live heap
    issue(FUNC_EXTRACT, KEY_MAX, KEY_MIN);
    issue(FUNC_INSERT, 0, KEY_MAX);
    issue(FUNC_INSERT, KEY_MAX, KEY_MIN);
    issue(FUNC_INSERT, KEY_MIN, -1);
    issue(FUNC_INSERT, -1, 0);
    issue(FUNC_INSERT, 5, 1);
    issue(FUNC_INSERT, 5, 2);
    issue(FUNC_INSERT, 5, 3);
    issue(FUNC_EXTRACT, -1, -1);
    issue(FUNC_EXTRACT, 0, 0);
    issue(FUNC_EXTRACT, KEY_MIN, KEY_MAX);
    set_order(MODE_MIN);
    issue(FUNC_EXTRACT, 0, 0);
    issue(FUNC_INSERT, KEY_MIN, 7);
    issue(FUNC_INSERT, 1, -7);
    issue(FUNC_INSERT, 1, 8);
    repeat (7) issue(FUNC_EXTRACT, 0, 0);
    set_order(MODE_MAX);

    // sender idles 21 in a hundred: mixed, then fill to overflow
    random_run(55, 21, 100, -1);
    random_run(88, 21, 0, CAPACITY);
    set_order(MODE_MIN);

    // sender idles 52 in a hundred: drain the reordered heap past empty
    random_run(12, 52, 0, 0);
    random_run(55, 52, 100, -1);
    set_order(MODE_MAX);

    // no idling, in both orders
    random_run(55, 0, 150, -1);
    set_order(MODE_MIN);
    random_run(55, 0, 150, -1);

    settle();
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
